// ===== src/mpid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpid_pkg: shared types and constants of the multi-pin debouncer
// Holds the controller state type, the command and status bundles between
// controller and datapath, and the register map of the configuration port.
// ----------------------------------------------------------------------------
package mpid_pkg;

    // Fixed field widths of the item, result and configuration ports.
    localparam int PIN_W    = 9;
    localparam int LIMIT_W  = 16;
    localparam int INDEX_W  = 4;
    localparam int ADDR_W   = 3;
    localparam int PDATA_W  = 32;

    // Register map: register index is paddr[2].
    localparam logic REG_LIMIT = 1'b0;
    localparam logic REG_MASK  = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'h0000;
    localparam logic [PIN_W-1:0]   MASK_RST  = 9'h1E9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;   // capture the item and restart the pin scan
        logic scan;   // process the current pin
        logic flush;  // release the held event as the last of the tick
    } cmd_t;

    typedef struct packed {
        logic stall;       // current pin has an event but nowhere to put it
        logic scan_last;   // current pin is the highest one
        logic pend_valid;  // an event is held back awaiting the last-flag
        logic out_free;    // output register can take a new event
    } sts_t;

endpackage

// ===== src/mpid_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpid_ctrl: sequencing controller
// Accepts one tick at a time, steps the datapath through the pins and then
// releases the held change event with its last-flag set.
// ----------------------------------------------------------------------------
module mpid_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output mpid_pkg::cmd_t cmd,
    input  mpid_pkg::sts_t sts
);
    import mpid_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!sts.stall && sts.scan_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!sts.pend_valid || sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        cmd.load  = 1'b0;
        cmd.scan  = 1'b0;
        cmd.flush = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_FLUSH: begin
                cmd.flush = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sts.pend_valid)
        else $error("event still held while idle");

    a_load_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_SCAN))
        else $error("accepted item did not start a scan");

    a_stall_holds_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && sts.stall) |=> (state_reg == ST_SCAN))
        else $error("scan left while stalled");
`endif

endmodule

// ===== src/mpid_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpid_dp: per-pin integrator datapath
// Holds the counters and debounced states, updates one pin per step, and
// keeps one event back so that the final event of a tick can be marked.
// ----------------------------------------------------------------------------
module mpid_dp #(
    parameter int NUM_PINS      = 9,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mpid_pkg::cmd_t                cmd,
    output mpid_pkg::sts_t                sts,
    input  logic                          s_port_open,
    input  logic [mpid_pkg::PIN_W-1:0]    s_pin_levels,
    input  logic [mpid_pkg::LIMIT_W-1:0]  limit,
    input  logic [mpid_pkg::PIN_W-1:0]    mask,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mpid_pkg::INDEX_W-1:0]  m_pin_index,
    output logic                          m_new_level,
    output logic                          m_last_event
);
    import mpid_pkg::*;

    localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam int CMP_W = (COUNTER_WIDTH > LIMIT_W) ? COUNTER_WIDTH : LIMIT_W;
    localparam logic [CMP_W-1:0] CNT_MAX  = CMP_W'({COUNTER_WIDTH{1'b1}});
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PINS - 1);

    logic [COUNTER_WIDTH-1:0] cnt_reg [NUM_PINS];
    logic [NUM_PINS-1:0]      deb_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [PIN_W-1:0]         levels_reg;
    logic                     open_reg;
    logic                     pend_valid_reg;
    logic [IDX_W-1:0]         pend_idx_reg;
    logic                     pend_lvl_reg;
    logic                     out_valid_reg;
    logic [INDEX_W-1:0]       out_idx_reg;
    logic                     out_lvl_reg;
    logic                     out_last_reg;

    logic [4:0]               idx5;
    logic [31:0]              lvl32;
    logic [31:0]              msk32;
    logic [31:0]              pidx32;
    logic                     pin_lvl;
    logic                     pin_en;
    logic [COUNTER_WIDTH-1:0] cnt_cur;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         lim_ext;
    logic [CMP_W-1:0]         lim_eff;
    logic                     deb_cur;
    logic [COUNTER_WIDTH-1:0] cnt_next;
    logic                     deb_next;
    logic                     event_hit;
    logic                     out_free;
    logic                     stall;
    logic                     step;
    logic                     flush_move;
    logic                     out_load;
    logic                     out_last_next;

    assign idx5    = 5'(idx_reg);
    assign lvl32   = 32'(levels_reg);
    assign msk32   = 32'(mask);
    assign pidx32  = 32'(pend_idx_reg);
    assign pin_lvl = lvl32[idx5];
    assign pin_en  = open_reg & msk32[idx5];
    assign cnt_cur = cnt_reg[idx_reg];
    assign deb_cur = deb_reg[idx_reg];
    assign cnt_ext = CMP_W'(cnt_cur);
    assign lim_ext = CMP_W'(limit);
    assign lim_eff = (lim_ext > CNT_MAX) ? CNT_MAX : lim_ext;

    // A counter that is moving absorbs the level; only a counter that sits
    // at its end lets the debounced state follow.
    always_comb begin
        cnt_next  = cnt_cur;
        deb_next  = deb_cur;
        event_hit = 1'b0;
        if (pin_en) begin
            if (pin_lvl) begin
                if (cnt_ext < lim_eff) begin
                    cnt_next = COUNTER_WIDTH'(cnt_cur + 1'b1);
                end else if (!deb_cur) begin
                    deb_next  = 1'b1;
                    event_hit = 1'b1;
                end
            end else begin
                if (cnt_cur != '0) begin
                    cnt_next = COUNTER_WIDTH'(cnt_cur - 1'b1);
                end else if (deb_cur) begin
                    deb_next  = 1'b0;
                    event_hit = 1'b1;
                end
            end
        end
    end

    assign out_free      = !out_valid_reg || m_ready;
    assign stall         = event_hit && pend_valid_reg && !out_free;
    assign step          = cmd.scan && !stall;
    assign flush_move    = cmd.flush && pend_valid_reg && out_free;
    assign out_load      = (step && event_hit && pend_valid_reg) || flush_move;
    assign out_last_next = flush_move;

    assign sts.stall      = stall;
    assign sts.scan_last  = (idx_reg == LAST_IDX);
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PINS; i++) begin
                cnt_reg[i] <= '0;
            end
            deb_reg        <= '0;
            idx_reg        <= '0;
            open_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg        <= '0;
                open_reg       <= s_port_open;
                pend_valid_reg <= 1'b0;
            end else if (step) begin
                cnt_reg[idx_reg] <= cnt_next;
                deb_reg[idx_reg] <= deb_next;
                if (idx_reg != LAST_IDX) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (event_hit) begin
                    pend_valid_reg <= 1'b1;
                end
            end else if (flush_move) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            levels_reg <= s_pin_levels;
        end
        if (step && event_hit) begin
            pend_idx_reg <= idx_reg;
            pend_lvl_reg <= deb_next;
        end
        if (out_load) begin
            out_idx_reg  <= pidx32[INDEX_W-1:0];
            out_lvl_reg  <= pend_lvl_reg;
            out_last_reg <= out_last_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_pin_index  = out_idx_reg;
    assign m_new_level  = out_lvl_reg;
    assign m_last_event = out_last_reg;

`ifndef SYNTHESIS
    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_move |=> !pend_valid_reg)
        else $error("held event not released by flush");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= LAST_IDX)
        else $error("pin index beyond the last pin");

    a_stall_keeps_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan && stall) |=> ($stable(idx_reg) && pend_valid_reg))
        else $error("pin advanced or event dropped during a stall");
`endif

endmodule

// ===== src/multi_pin_integrating_debouncer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pin_integrating_debouncer_unit: integrating debouncer for serial pins
// Each item is one sampling tick; each enabled pin integrates its raw level
// and emits a change event when its debounced state flips.
// ----------------------------------------------------------------------------
// Sequence: a tick is taken in the idle state, then the pins are scanned one
// per cycle through the single shared per-pin update step and a flush step
// releases the final event into the output register. A new tick is taken
// only after the flush; while a held-back event waits on a busy output, the
// scan (when the current pin has an event) or the flush stalls.
// Reset: counters and debounced states go to zero, the limit to 0 and the
// enable mask to 0x1E9; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_pin_integrating_debouncer_unit #(
    parameter int NUM_PINS      = 9,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mpid_pkg::ADDR_W-1:0]    paddr,
    input  logic [mpid_pkg::PDATA_W-1:0]   pwdata,
    output logic [mpid_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    // Tick input.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_port_open,
    input  logic [mpid_pkg::PIN_W-1:0]     s_pin_levels,
    // Change events.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mpid_pkg::INDEX_W-1:0]   m_pin_index,
    output logic                           m_new_level,
    output logic                           m_last_event
);
    import mpid_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic [PIN_W-1:0]   mask_reg;
    logic               reg_idx;
    logic               cfg_write;
    cmd_t               cmd;
    sts_t               sts;

    // The register index is the word address; the byte offset bits are
    // ignored, so every address decodes to one of the two registers.
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RST;
            mask_reg  <= MASK_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_LIMIT: limit_reg <= pwdata[LIMIT_W-1:0];
                REG_MASK:  mask_reg  <= pwdata[PIN_W-1:0];
                default:   limit_reg <= limit_reg;
            endcase
        end
    end

    // Read-back is combinational; the port never inserts wait states.
    always_comb begin
        unique case (reg_idx)
            REG_LIMIT: prdata = PDATA_W'(limit_reg);
            REG_MASK:  prdata = PDATA_W'(mask_reg);
            default:   prdata = '0;
        endcase
    end

    // The controller only sequences; every piece of per-pin state and the
    // output register live in the datapath.
    mpid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    mpid_dp #(
        .NUM_PINS      (NUM_PINS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_port_open  (s_port_open),
        .s_pin_levels (s_pin_levels),
        .limit        (limit_reg),
        .mask         (mask_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pin_index  (m_pin_index),
        .m_new_level  (m_new_level),
        .m_last_event (m_last_event)
    );

endmodule
